>>> rtl/fctm_pkg.sv
// shared constants, codes and transfer types for the fast-clear tag map
`timescale 1ns / 1ps

package fctm_pkg;

    localparam int MAP_DEPTH = 1024;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
    localparam int TAG_W     = 8;
    localparam int IDX_W     = 10;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WR,
        S_RD,
        S_CLR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] entry_index;
        logic [TAG_W-1:0] tag_value;
    } t_in;

    typedef struct packed {
        logic [TAG_W-1:0] read_tag;
        logic [1:0]       status;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [TAG_W-1:0]  wdata;
        logic              re;
        logic [MAP_AW-1:0] raddr;
    } t_tag_req;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [MAP_AW-1:0] wdata;
        logic              re;
        logic [MAP_AW-1:0] raddr;
    } t_list_req;

endpackage

>>> rtl/fast_clear_tag_map.sv
// top level of the fast-clear tag map: sequencer, tag and list memories, result register
`timescale 1ns / 1ps

//  channel   direction  handshake                      payload
//  request   in         i_in_valid / o_in_stall        i_in  (fctm_pkg::t_in)
//  result    out        o_out_valid / i_out_stall      o_out (fctm_pkg::t_out)
//
// one request at a time; a read or write reaches the result register after the
// tag memory read, then write-back or capture; a rejected or unused request, or a
// clear of an empty list, goes there directly; other clears first walk the list
// the next transfer follows once the result register has loaded and the sequencer
// is back in idle; no new request is taken while one is still in progress
// after reset the tag memory is swept to zero, with the input stalled
// a result waiting on a stalled output does not block the next request transfer

module fast_clear_tag_map (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  fctm_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output fctm_pkg::t_out  o_out
);

    fctm_pkg::t_tag_req             tag_req;
    fctm_pkg::t_list_req            list_req;
    logic [fctm_pkg::TAG_W-1:0]     tag_rdata;
    logic [fctm_pkg::MAP_AW-1:0]    list_rdata;
    logic                           res_valid;
    fctm_pkg::t_out                 res;
    logic                           slot_free;

    logic                           r_out_valid;
    fctm_pkg::t_out                 r_out;

    // output slot can take a new result when empty or being drained
    assign slot_free = !r_out_valid || !i_out_stall;

    fctm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .o_in_stall   (o_in_stall),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (slot_free),
        .o_tag_req    (tag_req),
        .i_tag_rdata  (tag_rdata),
        .o_list_req   (list_req),
        .i_list_rdata (list_rdata)
    );

    // tag per entry
    fctm_ram #(
        .WIDTH (fctm_pkg::TAG_W),
        .DEPTH (fctm_pkg::MAP_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_req.we),
        .i_waddr (tag_req.waddr),
        .i_wdata (tag_req.wdata),
        .i_re    (tag_req.re),
        .i_raddr (tag_req.raddr),
        .o_rdata (tag_rdata)
    );

    // indices of marked entries, valid below the count
    fctm_ram #(
        .WIDTH (fctm_pkg::MAP_AW),
        .DEPTH (fctm_pkg::MAP_DEPTH)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_req.we),
        .i_waddr (list_req.waddr),
        .i_wdata (list_req.wdata),
        .i_re    (list_req.re),
        .i_raddr (list_req.raddr),
        .o_rdata (list_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && slot_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/fctm_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps

module fctm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic                            i_re,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fctm_ctrl.sv
// request sequencer: init sweep, read-modify-write of tags, list walk on clear
`timescale 1ns / 1ps

module fctm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  fctm_pkg::t_in                  i_in,
    output logic                           o_in_stall,
    output logic                           o_res_valid,
    output fctm_pkg::t_out                 o_res,
    input  logic                           i_res_take,
    output fctm_pkg::t_tag_req             o_tag_req,
    input  logic [fctm_pkg::TAG_W-1:0]     i_tag_rdata,
    output fctm_pkg::t_list_req            o_list_req,
    input  logic [fctm_pkg::MAP_AW-1:0]    i_list_rdata
);

    fctm_pkg::t_state r_state, n_state;

    logic [fctm_pkg::MAP_AW-1:0] r_init, n_init;
    logic [fctm_pkg::MAP_AW-1:0] r_idx, n_idx;
    logic [fctm_pkg::TAG_W-1:0]  r_tag, n_tag;
    logic [fctm_pkg::MAP_AW-1:0] r_k, n_k;
    logic [fctm_pkg::CNT_W-1:0]  r_count, n_count;
    fctm_pkg::t_out              r_res, n_res;

    logic                        accept;
    logic                        idx_ok;
    logic                        tag_zero;
    logic                        init_last;
    logic                        clr_last;
    logic                        append;
    logic [fctm_pkg::MAP_AW-1:0] in_addr;

    assign accept    = i_in_valid && (r_state == fctm_pkg::S_IDLE);
    assign idx_ok    = 32'(i_in.entry_index) < fctm_pkg::MAP_DEPTH;
    assign tag_zero  = (i_in.tag_value == '0);
    assign in_addr   = fctm_pkg::MAP_AW'(i_in.entry_index);
    assign init_last = (r_init == fctm_pkg::MAP_AW'(fctm_pkg::MAP_DEPTH - 1));
    assign clr_last  = ((fctm_pkg::CNT_W'(r_k) + fctm_pkg::CNT_W'(1)) == r_count);
    // entry was empty before this write: list it
    assign append    = (i_tag_rdata == '0) && (32'(r_count) < fctm_pkg::MAP_DEPTH);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fctm_pkg::S_INIT: begin
                if (init_last) n_state = fctm_pkg::S_IDLE;
            end
            fctm_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_in.req_type)
                        fctm_pkg::REQ_WRITE: begin
                            n_state = (idx_ok && !tag_zero) ? fctm_pkg::S_WR
                                                            : fctm_pkg::S_DONE;
                        end
                        fctm_pkg::REQ_READ: begin
                            n_state = idx_ok ? fctm_pkg::S_RD : fctm_pkg::S_DONE;
                        end
                        fctm_pkg::REQ_CLEAR: begin
                            n_state = (r_count != '0) ? fctm_pkg::S_CLR
                                                      : fctm_pkg::S_DONE;
                        end
                        default: n_state = fctm_pkg::S_DONE;
                    endcase
                end
            end
            fctm_pkg::S_WR:  n_state = fctm_pkg::S_DONE;
            fctm_pkg::S_RD:  n_state = fctm_pkg::S_DONE;
            fctm_pkg::S_CLR: begin
                if (clr_last) n_state = fctm_pkg::S_DONE;
            end
            fctm_pkg::S_DONE: begin
                if (i_res_take) n_state = fctm_pkg::S_IDLE;
            end
            default: n_state = fctm_pkg::S_INIT;
        endcase
    end

    // outputs: memory requests and handshake
    always_comb begin
        o_tag_req   = '0;
        o_list_req  = '0;
        o_in_stall  = (r_state != fctm_pkg::S_IDLE);
        o_res_valid = (r_state == fctm_pkg::S_DONE);
        o_res       = r_res;
        unique case (r_state)
            fctm_pkg::S_INIT: begin
                o_tag_req.we    = 1'b1;
                o_tag_req.waddr = r_init;
            end
            fctm_pkg::S_IDLE: begin
                // speculative reads: tag for write/read, first list slot for clear
                o_tag_req.re  = 1'b1;
                o_tag_req.raddr = in_addr;
                o_list_req.re = 1'b1;
            end
            fctm_pkg::S_WR: begin
                o_tag_req.we    = 1'b1;
                o_tag_req.waddr = r_idx;
                o_tag_req.wdata = r_tag;
                if (append) begin
                    o_list_req.we    = 1'b1;
                    o_list_req.waddr = fctm_pkg::MAP_AW'(r_count);
                    o_list_req.wdata = r_idx;
                end
            end
            fctm_pkg::S_CLR: begin
                o_tag_req.we     = 1'b1;
                o_tag_req.waddr  = i_list_rdata;
                o_list_req.re    = 1'b1;
                o_list_req.raddr = r_k + fctm_pkg::MAP_AW'(1);
            end
            fctm_pkg::S_RD, fctm_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_init  = r_init;
        n_idx   = r_idx;
        n_tag   = r_tag;
        n_k     = r_k;
        n_count = r_count;
        n_res   = r_res;
        case (r_state)
            fctm_pkg::S_INIT: n_init = r_init + fctm_pkg::MAP_AW'(1);
            fctm_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx          = in_addr;
                    n_tag          = i_in.tag_value;
                    n_k            = '0;
                    n_res.read_tag = '0;
                    n_res.status   = fctm_pkg::ST_OK;
                    if ((i_in.req_type == fctm_pkg::REQ_WRITE) ||
                        (i_in.req_type == fctm_pkg::REQ_READ)) begin
                        if (!idx_ok) begin
                            n_res.status = fctm_pkg::ST_RANGE;
                        end else if ((i_in.req_type == fctm_pkg::REQ_WRITE) && tag_zero) begin
                            n_res.status = fctm_pkg::ST_ZERO;
                        end
                    end
                end
            end
            fctm_pkg::S_WR: begin
                if (append) n_count = r_count + fctm_pkg::CNT_W'(1);
            end
            fctm_pkg::S_RD: n_res.read_tag = i_tag_rdata;
            fctm_pkg::S_CLR: begin
                n_k = r_k + fctm_pkg::MAP_AW'(1);
                if (clr_last) n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fctm_pkg::S_INIT;
            r_init  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_count <= n_count;
        end
        r_idx <= n_idx;
        r_tag <= n_tag;
        r_k   <= n_k;
        r_res <= n_res;
    end

endmodule

>>> sim/testbench.sv
// self-checking testbench for the fast-clear tag map: directed and random requests
`timescale 1ns / 1ps

module testbench;

    // request code with no operation behind it
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOT_POOL     = 32;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    fctm_pkg::t_in   i_in;
    logic            o_out_valid;
    logic            i_out_stall;
    fctm_pkg::t_out  o_out;

    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_req_count;
    int     hold_done_count;
    int     cycle_count = 0;

    // mirror of the tag store and marked list, plus the results still owed
    class tag_map_scoreboard;
        logic [fctm_pkg::TAG_W-1:0] tags [fctm_pkg::MAP_DEPTH];
        logic [fctm_pkg::IDX_W-1:0] marked [$];
        fctm_pkg::t_out             owed_results [$];
        int                         err_count;

        function new();
            foreach (tags[k]) tags[k] = '0;
            err_count = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            err_count++;
        endtask

        function int pending();
            return owed_results.size();
        endfunction

        function void note_request(input fctm_pkg::t_in req);
            fctm_pkg::t_out res;
            res.read_tag = '0;
            res.status   = fctm_pkg::ST_OK;
            if (req.req_type == fctm_pkg::REQ_WRITE) begin
                if (int'(req.entry_index) >= fctm_pkg::MAP_DEPTH) begin
                    res.status = fctm_pkg::ST_RANGE;
                end else if (req.tag_value == '0) begin
                    res.status = fctm_pkg::ST_ZERO;
                end else begin
                    // only a fresh entry goes on the list
                    if (tags[req.entry_index] == '0 && marked.size() < fctm_pkg::MAP_DEPTH)
                        marked.push_back(req.entry_index);
                    tags[req.entry_index] = req.tag_value;
                end
            end else if (req.req_type == fctm_pkg::REQ_READ) begin
                if (int'(req.entry_index) >= fctm_pkg::MAP_DEPTH)
                    res.status = fctm_pkg::ST_RANGE;
                else
                    res.read_tag = tags[req.entry_index];
            end else if (req.req_type == fctm_pkg::REQ_CLEAR) begin
                foreach (marked[k]) tags[marked[k]] = '0;
                marked.delete();
            end
            owed_results.push_back(res);
        endfunction

        task check_result(input fctm_pkg::t_out got);
            fctm_pkg::t_out want;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result tag %0d status %0d",
                                 got.read_tag, got.status));
            end else begin
                want = owed_results.pop_front();
                if (got.read_tag !== want.read_tag)
                    report($sformatf("read_tag %0d, expected %0d",
                                     got.read_tag, want.read_tag));
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d",
                                     got.status, want.status));
            end
        endtask
    endclass

    tag_map_scoreboard sb = new();

    fast_clear_tag_map uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // transfers on both channels, seen at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_in);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[fast_clear_tag_map] ERROR");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off when one is asked for
    initial begin
        i_out_stall     = 1'b0;
        hold_done_count = 0;
        forever begin
            @(negedge i_clk);
            if (hold_done_count != hold_req_count) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_done_count++;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic fctm_pkg::t_in mk_req(input logic [1:0] kind, input int idx,
                                             input int tag);
        fctm_pkg::t_in r;
        r.req_type    = kind;
        r.entry_index = idx[fctm_pkg::IDX_W-1:0];
        r.tag_value   = tag[fctm_pkg::TAG_W-1:0];
        return r;
    endfunction

    // mostly a small set of hot entries so reads and rewrites hit listed ones
    function automatic int pick_index();
        if ($urandom_range(99) < 70)
            return $urandom_range(HOT_POOL - 1);
        return $urandom_range(fctm_pkg::MAP_DEPTH - 1);
    endfunction

    function automatic fctm_pkg::t_in random_req();
        int sel;
        int tag;
        sel = $urandom_range(99);
        if (sel < 55) begin
            if ($urandom_range(11) == 0)
                tag = 0;
            else
                tag = $urandom_range(255, 1);
            return mk_req(fctm_pkg::REQ_WRITE, pick_index(), tag);
        end else if (sel < 88) begin
            return mk_req(fctm_pkg::REQ_READ, pick_index(), $urandom_range(255));
        end else if (sel < 95) begin
            return mk_req(fctm_pkg::REQ_CLEAR, $urandom_range(fctm_pkg::MAP_DEPTH - 1),
                          $urandom_range(255));
        end
        return mk_req(REQ_UNUSED, $urandom_range(fctm_pkg::MAP_DEPTH - 1),
                      $urandom_range(255));
    endfunction

    task automatic send_request(input fctm_pkg::t_in item);
        bit taken;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in       <= fctm_pkg::t_in'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_request(random_req());
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        hold_req_count = 0;
        send_idle_pct  = 22;
        recv_idle_pct  = 75;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of index and tag, unwritten read, zero tag, rewrite, clears
        send_request(mk_req(fctm_pkg::REQ_WRITE, 0, 1));
        send_request(mk_req(fctm_pkg::REQ_WRITE, fctm_pkg::MAP_DEPTH - 1, 255));
        send_request(mk_req(fctm_pkg::REQ_READ, 0, 0));
        send_request(mk_req(fctm_pkg::REQ_READ, fctm_pkg::MAP_DEPTH - 1, 255));
        send_request(mk_req(fctm_pkg::REQ_READ, 5, 0));
        send_request(mk_req(fctm_pkg::REQ_WRITE, 0, 0));
        send_request(mk_req(fctm_pkg::REQ_WRITE, fctm_pkg::MAP_DEPTH - 1, 0));
        send_request(mk_req(fctm_pkg::REQ_WRITE, 0, 8'h80));
        send_request(mk_req(fctm_pkg::REQ_READ, 0, 0));
        send_request(mk_req(REQ_UNUSED, 10'h3FF, 8'hFF));
        send_request(mk_req(REQ_UNUSED, 0, 0));
        send_request(mk_req(fctm_pkg::REQ_WRITE, 512, 8'h7F));
        send_request(mk_req(fctm_pkg::REQ_WRITE, 10'h155, 8'h55));
        send_request(mk_req(fctm_pkg::REQ_WRITE, 10'h2AA, 8'hAA));
        send_request(mk_req(fctm_pkg::REQ_CLEAR, 10'h3FF, 8'hFF));
        send_request(mk_req(fctm_pkg::REQ_READ, 0, 0));
        send_request(mk_req(fctm_pkg::REQ_READ, fctm_pkg::MAP_DEPTH - 1, 0));
        send_request(mk_req(fctm_pkg::REQ_READ, 512, 0));
        send_request(mk_req(fctm_pkg::REQ_CLEAR, 0, 0));
        send_request(mk_req(fctm_pkg::REQ_WRITE, fctm_pkg::MAP_DEPTH - 1, 8'hAA));
        send_request(mk_req(fctm_pkg::REQ_READ, fctm_pkg::MAP_DEPTH - 1, 8'h55));
        send_request(mk_req(fctm_pkg::REQ_READ, 10'h2AA, 0));

        send_random(PHASE_ITEMS);

        // sender holds back until the block has answered everything
        wait_drained();
        send_idle_pct = 75;
        recv_idle_pct = 22;
        send_random(PHASE_ITEMS);

        // no idling; a long result hold-off backs the block up into its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_count++;
        send_random(PHASE_ITEMS);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.err_count == 0) begin
            $display("[fast_clear_tag_map] OK");
        end else begin
            $display("[fast_clear_tag_map] ERROR");
        end
        $finish;
    end

endmodule
